[rtl/tfr_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// tfr_pkg - shared types and constants of the telemetry frame receiver
// Frame table, result codes, queue entry layout and small decode helpers.
// ============================================================================
package tfr_pkg;

    localparam int HISTORY_BYTES_DEF = 34;
    localparam int WIN_BYTES         = 34;
    localparam int NUM_KINDS         = 6;
    localparam int VAL_W             = 18;
    localparam int CFG_W             = 16;
    localparam int CFG_ADDR_W        = 2;
    localparam int TDATA_OUT_W       = 112;

    localparam logic [7:0] SYNC_BYTE = 8'hFD;

    localparam logic [2:0] KIND_VELOCITY = 3'd0;
    localparam logic [2:0] KIND_WHEELS   = 3'd1;
    localparam logic [2:0] KIND_BATTERY  = 3'd2;
    localparam logic [2:0] KIND_HEADING  = 3'd3;
    localparam logic [2:0] KIND_INERTIAL = 3'd4;
    localparam logic [2:0] KIND_CHASSIS  = 3'd5;
    localparam logic [2:0] KIND_BAD_CHK  = 3'd6;

    localparam logic [CFG_ADDR_W-1:0] REG_LIN_DB  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ANG_DB  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BAT_LOW = 2'd2;

    localparam int LEN_VEL = 13;
    localparam int LEN_WHL = 12;
    localparam int LEN_BAT = 5;
    localparam int LEN_HDG = 13;
    localparam int LEN_IMU = 34;
    localparam int LEN_CHS = 5;

    localparam logic signed [VAL_W-1:0] FULL_TURN = 18'sd36000;
    localparam logic signed [VAL_W-1:0] HALF_TURN = 18'sd18000;

    typedef logic [WIN_BYTES-1:0][7:0] win_t;

    typedef struct packed {
        logic [NUM_KINDS-1:0] hit;
        logic [NUM_KINDS-1:0] ok;
        win_t                 win;
    } entry_t;

    typedef struct packed {
        logic [15:0] lin_db;
        logic [15:0] ang_db;
        logic [7:0]  bat_low;
    } cfg_t;

    function automatic int frame_len(input int k);
        case (k)
            0: return LEN_VEL;
            1: return LEN_WHL;
            2: return LEN_BAT;
            3: return LEN_HDG;
            4: return LEN_IMU;
            default: return LEN_CHS;
        endcase
    endfunction

    function automatic logic [7:0] frame_lcode(input int k);
        case (k)
            0, 3: return 8'h0A;
            1: return 8'h09;
            4: return 8'h1F;
            default: return 8'h02;
        endcase
    endfunction

    function automatic logic [7:0] frame_tcode(input int k);
        return 8'(k + 2);
    endfunction

    // Byte i of a frame of length len that ends at the newest window byte.
    function automatic logic [7:0] fb(input win_t w, input int len, input int i);
        return w[WIN_BYTES - len + i];
    endfunction

    function automatic logic [15:0] u16(input logic [7:0] hi, input logic [7:0] lo);
        return {hi, lo};
    endfunction

    function automatic logic signed [VAL_W-1:0] sm_val(input logic [7:0] s,
                                                       input logic [7:0] hi,
                                                       input logic [7:0] lo);
        logic signed [VAL_W-1:0] m;
        m = $signed({2'b00, hi, lo});
        return (s != 8'd0) ? -m : m;
    endfunction

endpackage

[rtl/tfr_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// tfr_front - byte history and frame classifier
// Shifts each beat into the history and tests all six frame headers and checks.
// ============================================================================
module tfr_front import tfr_pkg::*; #(
    parameter int HISTORY_BYTES = HISTORY_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       push,
    output entry_t     push_entry
);

    logic [HISTORY_BYTES-1:0][7:0] hist_reg, hist_next;
    win_t                          win;
    logic [NUM_KINDS-1:0]          hit, ok;

    always_comb begin
        for (int j = 0; j < HISTORY_BYTES - 1; j++) hist_next[j] = hist_reg[j+1];
        hist_next[HISTORY_BYTES-1] = byte_data;
        for (int j = 0; j < WIN_BYTES; j++) win[j] = hist_next[HISTORY_BYTES - WIN_BYTES + j];
    end

    always_comb begin
        logic [7:0] x;
        for (int k = 0; k < NUM_KINDS; k++) begin
            hit[k] = (fb(win, frame_len(k), 0) == SYNC_BYTE) &&
                     (fb(win, frame_len(k), 1) == frame_lcode(k)) &&
                     (fb(win, frame_len(k), 2) == frame_tcode(k));
            x = 8'd0;
            for (int i = 2; i < WIN_BYTES - 1; i++)
                if (i + 1 < frame_len(k)) x = x ^ fb(win, frame_len(k), i);
            ok[k] = (x == fb(win, frame_len(k), frame_len(k) - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (byte_valid) begin
            hist_reg <= hist_next;
        end
    end

    assign push            = byte_valid && (hit != '0);
    assign push_entry.hit  = hit;
    assign push_entry.ok   = ok;
    assign push_entry.win  = win;

endmodule

[rtl/tfr_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// tfr_queue - two-entry queue between classifier and decoder
// Holds classified frame windows until the decoder takes them.
// ============================================================================
module tfr_queue import tfr_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_entry;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue underflow");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count slip");

endmodule

[rtl/tfr_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// tfr_back - frame decoder and result register
// Walks one entry's hit mask in kind order, one beat per cycle unless stalled.
// ============================================================================
module tfr_back import tfr_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  entry_t                 head,
    input  logic                   q_empty,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast
);

    logic                   busy_reg;
    entry_t                 ent_reg;
    logic [NUM_KINDS-1:0]   mask_reg, sel_1h;
    logic [2:0]             sel;
    logic                   emit, slot_free;
    logic                   hdg_cap_reg;
    logic signed [VAL_W-1:0] ref_hdg_reg;
    logic                   out_valid_reg, out_last_reg;
    logic [TDATA_OUT_W-1:0] out_data_reg;
    logic [2:0]             kind;
    logic signed [VAL_W-1:0] va, vb, vc, vd, ve, vf, yaw, rel;
    logic [15:0]            m0, m1, m2;
    win_t                   w;

    assign slot_free = !out_valid_reg || m_tready;
    assign emit      = busy_reg && slot_free;
    assign pop       = !busy_reg && !q_empty;
    assign w         = ent_reg.win;

    always_comb begin
        sel = 3'd0;
        for (int k = NUM_KINDS - 1; k >= 0; k--)
            if (mask_reg[k]) sel = 3'(k);
        sel_1h = NUM_KINDS'(1) << sel;
    end

    // Decode the selected kind.
    always_comb begin
        va = '0; vb = '0; vc = '0; vd = '0; ve = '0; vf = '0;
        kind = sel;
        m0 = '0; m1 = '0; m2 = '0;
        yaw = sm_val(fb(w, LEN_HDG, 9), fb(w, LEN_HDG, 10), fb(w, LEN_HDG, 11));
        if (yaw < 0) yaw = yaw + FULL_TURN;
        rel = ref_hdg_reg - yaw;
        if (rel > HALF_TURN) rel = rel - FULL_TURN;
        if (rel < -HALF_TURN) rel = rel + FULL_TURN;
        if (!ent_reg.ok[sel]) begin
            kind = KIND_BAD_CHK;
            va   = VAL_W'(sel);
        end else begin
            unique case (sel)
                KIND_VELOCITY: begin
                    m0 = u16(fb(w, LEN_VEL, 4), fb(w, LEN_VEL, 5));
                    m1 = u16(fb(w, LEN_VEL, 7), fb(w, LEN_VEL, 8));
                    m2 = u16(fb(w, LEN_VEL, 10), fb(w, LEN_VEL, 11));
                    va = (m0 <= cfg.lin_db) ? '0 :
                         sm_val(fb(w, LEN_VEL, 3), fb(w, LEN_VEL, 4), fb(w, LEN_VEL, 5));
                    vb = (m1 <= cfg.lin_db) ? '0 :
                         sm_val(fb(w, LEN_VEL, 6), fb(w, LEN_VEL, 7), fb(w, LEN_VEL, 8));
                    vc = (m2 <= cfg.ang_db) ? '0 :
                         sm_val(fb(w, LEN_VEL, 9), fb(w, LEN_VEL, 10), fb(w, LEN_VEL, 11));
                end
                KIND_WHEELS: begin
                    va = $signed({2'b00, u16(fb(w, LEN_WHL, 3), fb(w, LEN_WHL, 4))});
                    vb = $signed({2'b00, u16(fb(w, LEN_WHL, 5), fb(w, LEN_WHL, 6))});
                    vc = $signed({2'b00, u16(fb(w, LEN_WHL, 7), fb(w, LEN_WHL, 8))});
                    vd = $signed({2'b00, u16(fb(w, LEN_WHL, 9), fb(w, LEN_WHL, 10))});
                end
                KIND_BATTERY: begin
                    va = $signed({10'd0, fb(w, LEN_BAT, 3)});
                    vb = (fb(w, LEN_BAT, 3) < cfg.bat_low) ? 18'sd1 : 18'sd0;
                end
                KIND_HEADING: begin
                    va = hdg_cap_reg ? rel : '0;
                    vb = yaw;
                end
                KIND_INERTIAL: begin
                    va = -sm_val(fb(w, LEN_IMU, 3), fb(w, LEN_IMU, 4), fb(w, LEN_IMU, 5));
                    vb = sm_val(fb(w, LEN_IMU, 6), fb(w, LEN_IMU, 7), fb(w, LEN_IMU, 8));
                    vc = sm_val(fb(w, LEN_IMU, 9), fb(w, LEN_IMU, 10), fb(w, LEN_IMU, 11));
                    vd = -sm_val(fb(w, LEN_IMU, 12), fb(w, LEN_IMU, 13), fb(w, LEN_IMU, 14));
                    ve = sm_val(fb(w, LEN_IMU, 15), fb(w, LEN_IMU, 16), fb(w, LEN_IMU, 17));
                    vf = sm_val(fb(w, LEN_IMU, 18), fb(w, LEN_IMU, 19), fb(w, LEN_IMU, 20));
                end
                default: begin
                    va = $signed({10'd0, fb(w, LEN_CHS, 3)});
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) ent_reg <= head;
        if (emit) begin
            out_data_reg <= {1'b0, vf, ve, vd, vc, vb, va, kind};
            out_last_reg <= ((mask_reg & ~sel_1h) == '0);
        end
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            hdg_cap_reg   <= 1'b0;
            ref_hdg_reg   <= '0;
        end else begin
            if (pop) begin
                busy_reg <= 1'b1;
                mask_reg <= head.hit;
            end else if (emit) begin
                mask_reg <= mask_reg & ~sel_1h;
                if ((mask_reg & ~sel_1h) == '0) busy_reg <= 1'b0;
            end
            if (emit) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            // Capture the reference on the first good heading frame.
            if (emit && sel == KIND_HEADING && ent_reg.ok[sel] && !hdg_cap_reg) begin
                hdg_cap_reg <= 1'b1;
                ref_hdg_reg <= yaw;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_busy_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (mask_reg != '0)) else $error("busy with empty mask");
    a_cap_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        hdg_cap_reg |=> hdg_cap_reg) else $error("heading capture lost");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !emit) else $error("pop while emitting");

endmodule

[rtl/telemetry_frame_receiver_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// telemetry_frame_receiver_core - serial telemetry frame receiver
// Recognizes six telemetry frame types in a byte stream and decodes them.
// ============================================================================
// Usage:
//   s_ channel: one received serial byte per beat in s_tdata[7:0].
//   m_ channel: one decoded result per beat; m_tdata holds, from bit 0 up,
//   frame_kind[2:0], val_a..val_f (18 bit each), one pad bit. m_tlast marks
//   the final result caused by one input byte. Bytes that complete no
//   frame header produce no beat at all.
//   cfg_ port: write linear deadband (0), angular deadband (1) and battery
//   low level (2) while the block is idle.
// Path: a byte's entry passes the queue and the decoder's entry register to
//   the result register; its further results follow one per cycle while
//   m_tready is high.
// Throughput: one byte per cycle while the two-entry queue has room; the
//   decoder takes a new entry only after all results of the last one.
// Reset: history clears to zero, heading reference is forgotten, the
//   registers return to 10, 1 and 100.
// Stall: when m_tready is low the result register holds, the decoder
//   waits, the queue fills and s_tready drops once it is full.
// ============================================================================
module telemetry_frame_receiver_core import tfr_pkg::*; #(
    parameter int HISTORY_BYTES = HISTORY_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // rx_byte[7:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // frame_kind[2:0], val_a, val_b, val_c, val_d, val_e, val_f, pad[111]
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    cfg_t   cfg_reg;
    logic   push, pop, q_empty, q_full, accept;
    entry_t push_entry, head;

    // Hold input while the queue is full; a beat that matches nothing still
    // only shifts the history.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lin_db  <= 16'd10;
            cfg_reg.ang_db  <= 16'd1;
            cfg_reg.bat_low <= 8'd100;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LIN_DB:  cfg_reg.lin_db  <= cfg_wdata;
                REG_ANG_DB:  cfg_reg.ang_db  <= cfg_wdata;
                REG_BAT_LOW: cfg_reg.bat_low <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    tfr_front #(.HISTORY_BYTES(HISTORY_BYTES)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (accept),
        .byte_data  (s_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    tfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    tfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/sv/tb_telemetry_frame_receiver_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_telemetry_frame_receiver_core - self-checking bench of the frame receiver
// Feeds serial byte streams built from well-formed, corrupted and random
// telemetry frames, predicts every decoded beat and compares it per field.
// ============================================================================
module tb_telemetry_frame_receiver_core;
    import tfr_pkg::*;

    typedef struct {
        logic [2:0]              kind;
        logic signed [VAL_W-1:0] val [6];
        logic                    last;
    } frame_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;     // rx_byte[7:0]
    logic                   m_tvalid;
    logic                   m_tready;
    // frame_kind[2:0], val_a..val_f (18 bit each), pad[111]
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;

    telemetry_frame_receiver_core dut (.*);

    // Predictor state: byte history, heading reference and register copies.
    logic [7:0]              rx_history [34];
    bit                      hdg_captured;
    logic signed [VAL_W-1:0] hdg_reference;
    logic [15:0]             lin_band;
    logic [15:0]             ang_band;
    logic [7:0]              bat_level;

    frame_result_t expected_results [$];
    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;

    localparam int LENS  [6] = '{13, 12, 5, 13, 34, 5};
    localparam logic [7:0] LCODES [6] = '{8'h0A, 8'h09, 8'h02, 8'h0A, 8'h1F, 8'h02};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [7:0] frame_byte(int len, int i);
        return rx_history[34 - len + i];
    endfunction

    function automatic logic signed [VAL_W-1:0] signed_mag(int len, int i);
        logic signed [VAL_W-1:0] mag;
        mag = $signed({2'b00, frame_byte(len, i + 1), frame_byte(len, i + 2)});
        return (frame_byte(len, i) != 8'd0) ? -mag : mag;
    endfunction

    function automatic logic signed [VAL_W-1:0] apply_band(logic signed [VAL_W-1:0] v,
                                                           logic [15:0] band);
        logic signed [VAL_W-1:0] mag;
        mag = (v < 0) ? -v : v;
        return (mag <= $signed({2'b00, band})) ? '0 : v;
    endfunction

    // Shift one byte in and queue every frame result it completes.
    task automatic predict_frames(input logic [7:0] rx);
        frame_result_t r;
        logic [7:0] chk;
        logic signed [VAL_W-1:0] yaw, rel;
        int first_new;
        first_new = expected_results.size();
        for (int i = 0; i < 33; i++) rx_history[i] = rx_history[i + 1];
        rx_history[33] = rx;
        for (int k = 0; k < 6; k++) begin
            int len;
            len = LENS[k];
            if (frame_byte(len, 0) != SYNC_BYTE || frame_byte(len, 1) != LCODES[k] ||
                frame_byte(len, 2) != 8'(k + 2)) continue;
            chk = '0;
            for (int i = 2; i < len - 1; i++) chk ^= frame_byte(len, i);
            r.last = 1'b0;
            foreach (r.val[j]) r.val[j] = '0;
            if (chk != frame_byte(len, len - 1)) begin
                r.kind   = KIND_BAD_CHK;
                r.val[0] = VAL_W'(k);
                expected_results.push_back(r);
                continue;
            end
            r.kind = 3'(k);
            case (3'(k))
                KIND_VELOCITY: begin
                    r.val[0] = apply_band(signed_mag(len, 3), lin_band);
                    r.val[1] = apply_band(signed_mag(len, 6), lin_band);
                    r.val[2] = apply_band(signed_mag(len, 9), ang_band);
                end
                KIND_WHEELS: begin
                    for (int j = 0; j < 4; j++)
                        r.val[j] = {2'b00, frame_byte(len, 3 + 2 * j), frame_byte(len, 4 + 2 * j)};
                end
                KIND_BATTERY: begin
                    r.val[0] = {10'd0, frame_byte(len, 3)};
                    r.val[1] = {17'd0, frame_byte(len, 3) < bat_level};
                end
                KIND_HEADING: begin
                    yaw = signed_mag(len, 9);
                    rel = '0;
                    if (yaw < 0) yaw += FULL_TURN;
                    if (!hdg_captured) begin
                        hdg_reference = yaw;
                        hdg_captured  = 1'b1;
                    end else begin
                        rel = hdg_reference - yaw;
                        if (rel > HALF_TURN) rel -= FULL_TURN;
                        if (rel < -HALF_TURN) rel += FULL_TURN;
                    end
                    r.val[0] = rel;
                    r.val[1] = yaw;
                end
                KIND_INERTIAL: begin
                    for (int j = 0; j < 6; j++) r.val[j] = signed_mag(len, 3 + 3 * j);
                    r.val[0] = -r.val[0];
                    r.val[3] = -r.val[3];
                end
                default: r.val[0] = {10'd0, frame_byte(len, 3)};
            endcase
            expected_results.push_back(r);
        end
        if (expected_results.size() > first_new)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    // Drive one byte beat, idling first at the current rate.
    task automatic send_byte(input logic [7:0] rx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        predict_frames(rx);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Build and send a frame of kind k; corrupt flips the check byte.
    task automatic send_frame(input int k, input bit corrupt, input logic [7:0] body [34]);
        logic [7:0] f [34];
        logic [7:0] chk;
        int len;
        len  = LENS[k];
        f    = body;
        f[0] = SYNC_BYTE;
        f[1] = LCODES[k];
        f[2] = 8'(k + 2);
        chk  = '0;
        for (int i = 2; i < len - 1; i++) chk ^= f[i];
        f[len - 1] = corrupt ? ~chk : chk;
        for (int i = 0; i < len; i++) send_byte(f[i]);
    endtask

    task automatic random_body(output logic [7:0] b [34]);
        for (int i = 0; i < 34; i++) begin
            case ($urandom_range(3))
                0: b[i] = 8'h00;
                1: b[i] = 8'hFF;
                default: b[i] = 8'($urandom);
            endcase
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LIN_DB: lin_band  = value;
            REG_ANG_DB: ang_band  = value;
            default:    bat_level = value[7:0];
        endcase
        @(posedge aclk);
    endtask

    // Check each result beat against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            frame_result_t exp_r;
            string tags;
            tags = "abcdef";
            if (expected_results.size() == 0) begin
                $error("unexpected result beat tdata=%h", m_tdata);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[2:0] !== exp_r.kind) begin
                    $error("frame_kind expected %0d actual %0d", exp_r.kind, m_tdata[2:0]);
                    error_count++;
                end
                for (int j = 0; j < 6; j++) begin
                    if (m_tdata[3 + 18 * j +: 18] !== exp_r.val[j]) begin
                        $error("val_%c expected %0d actual %0d", tags[j], exp_r.val[j],
                               $signed(m_tdata[3 + 18 * j +: 18]));
                        error_count++;
                    end
                end
                if (m_tlast !== exp_r.last) begin
                    $error("last expected %0b actual %0b", exp_r.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall process; hold_off forces a long stretch of backpressure.
    always @(posedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Extremes of every field, every kind, failed checks, negative zero.
    task automatic test_directed();
        logic [7:0] b [34];
        foreach (b[i]) b[i] = 8'h00;
        b[3] = 8'h01; b[4] = 8'h00; b[5] = 8'h00;           // negative zero
        b[6] = 8'h00; b[7] = 8'hFF; b[8] = 8'hFF;
        b[9] = 8'h01; b[10] = 8'h00; b[11] = 8'h01;         // yaw at deadband
        send_frame(0, 0, b);
        send_frame(3, 0, b);                                 // captures reference
        b[9] = 8'h00; b[10] = 8'h8C; b[11] = 8'h9F;          // 35999 wraps
        send_frame(3, 0, b);
        send_frame(1, 0, b);
        b[3] = 8'd99; send_frame(2, 0, b);
        b[3] = 8'd100; send_frame(2, 0, b);
        foreach (b[i]) b[i] = 8'hFF;
        send_frame(4, 0, b);
        send_frame(5, 0, b);
        for (int k = 0; k < 6; k++) send_frame(k, 1, b);
        send_byte(8'h00);
    endtask

    // Overlapping frames: a chassis frame ending inside a battery frame etc.
    task automatic test_random_frames(input int n_frames);
        logic [7:0] b [34];
        for (int n = 0; n < n_frames; n++) begin
            random_body(b);
            if ($urandom_range(9) < 8) send_frame($urandom_range(5), $urandom_range(9) == 0, b);
            else for (int i = 0; i < $urandom_range(1, 6); i++) send_byte(8'($urandom));
        end
    endtask

    // Single byte that closes a velocity frame and the battery frame at its
    // tail, twice.
    task automatic test_multi_match();
        for (int n = 0; n < 2; n++) begin
            send_byte(SYNC_BYTE); send_byte(8'h0A); send_byte(8'h02); send_byte(8'hFD);
            send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
            send_byte(SYNC_BYTE); send_byte(8'h02); send_byte(8'h04); send_byte(8'h30);
            send_byte(8'h34);
        end
    endtask

    // Fill the block while the receiver holds off.
    task automatic test_backpressure();
        logic [7:0] b [34];
        hold_off = 1'b1;
        fork
            begin
                random_body(b);
                for (int k = 0; k < 6; k++) send_frame(k % 3 + 1, 0, b);
            end
            begin
                int cnt;
                for (cnt = 0; cnt < 400; cnt++) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
    endtask

    initial begin
        error_count = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        cfg_wr_en = 1'b0; cfg_addr = REG_LIN_DB; cfg_wdata = '0;
        foreach (rx_history[i]) rx_history[i] = '0;
        hdg_captured = 1'b0; hdg_reference = '0;
        lin_band = 16'd10; ang_band = 16'd1; bat_level = 8'd100;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_multi_match();
        wait_drained();

        write_reg(REG_LIN_DB, 16'd0); write_reg(REG_ANG_DB, 16'd0); write_reg(REG_BAT_LOW, 16'd0);
        send_idle_pct = 84;
        test_random_frames(2);
        wait_drained();

        write_reg(REG_LIN_DB, 16'hFFFF); write_reg(REG_ANG_DB, 16'hFFFF);
        write_reg(REG_BAT_LOW, 16'h00FF);
        send_idle_pct = 0; recv_stall_pct = 84;
        test_random_frames(2);
        test_directed();
        wait_drained();

        write_reg(REG_LIN_DB, 16'($urandom)); write_reg(REG_ANG_DB, 16'($urandom_range(300)));
        write_reg(REG_BAT_LOW, 16'($urandom_range(255)));
        send_idle_pct = 8; recv_stall_pct = 8;
        test_random_frames(3);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_backpressure();
        test_random_frames(1);
        wait_drained();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[telemetry_frame_receiver_core.f]
rtl/tfr_pkg.sv
rtl/tfr_front.sv
rtl/tfr_queue.sv
rtl/tfr_back.sv
rtl/telemetry_frame_receiver_core.sv
tb/sv/tb_telemetry_frame_receiver_core.sv
